@@ rtl/ictf_pkg.sv @@
// Shared constants, types and elaboration-time table functions of the tilt filter.
package ictf_pkg;

	// defaults for the top-level parameters
	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 16;

	// CORDIC angle accumulator is degrees in Q30
	localparam int CORDIC_ZQ = 30;
	localparam logic [63:0] DEG_PER_RAD_Q26 = 64'd3845054675;

	// configuration port
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_FS = 2'd1;
	localparam logic [CFG_W-1:0] ALPHA_RESET = 17'd64881;
	localparam logic [CFG_W-1:0] ALPHA_ONE   = 17'd65536;

	// gyro full-scale codes
	localparam logic [1:0] FS_250  = 2'd0;
	localparam logic [1:0] FS_500  = 2'd1;
	localparam logic [1:0] FS_1000 = 2'd2;
	localparam logic [1:0] FS_2000 = 2'd3;

	// divisor width: 10x sensitivity times 1e6
	localparam int DEN_W = 31;

	// reciprocals of the divisors are scaled by 2^RCP_SHIFT and fit in 32 bits
	localparam int RCP_SHIFT = 59;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ATAN_GO,
		ST_ATAN_RUN,
		ST_GMUL,
		ST_DIV_GO,
		ST_DIV_RUN,
		ST_BMUL,
		ST_BFIN,
		ST_EMIT
	} ictf_state_t;

	// divider phases: estimate, back-multiply, fix-up
	typedef enum logic [1:0] {
		DV_IDLE,
		DV_MUL1,
		DV_MUL2,
		DV_FIX
	} div_state_t;

	// divisor for the gyro increment, per full-scale code
	function automatic logic [DEN_W-1:0] gyro_den(input logic [1:0] fs);
		logic [DEN_W-1:0] d;
		case (fs)
			FS_250:  d = 31'd1310000000;
			FS_500:  d = 31'd655000000;
			FS_1000: d = 31'd328000000;
			FS_2000: d = 31'd164000000;
			default: d = 31'd1310000000;
		endcase
		return d;
	endfunction

	// shift-subtract long division, only used at elaboration
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// floor(2^RCP_SHIFT / divisor), per full-scale code
	localparam logic [31:0] RCP_250  = 32'(udiv64(64'd1 << RCP_SHIFT, 64'd1310000000));
	localparam logic [31:0] RCP_500  = 32'(udiv64(64'd1 << RCP_SHIFT, 64'd655000000));
	localparam logic [31:0] RCP_1000 = 32'(udiv64(64'd1 << RCP_SHIFT, 64'd328000000));
	localparam logic [31:0] RCP_2000 = 32'(udiv64(64'd1 << RCP_SHIFT, 64'd164000000));

	function automatic logic [31:0] gyro_recip(input logic [1:0] fs);
		logic [31:0] r;
		case (fs)
			FS_250:  r = RCP_250;
			FS_500:  r = RCP_500;
			FS_1000: r = RCP_1000;
			FS_2000: r = RCP_2000;
			default: r = RCP_250;
		endcase
		return r;
	endfunction

	// atan(2^-i) in degrees, Q30: arctan series in Q62, rounded to Q32, scaled by 180/pi
	function automatic logic [63:0] atan_deg_q30(input int unsigned i);
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] term;
		logic [63:0] rad32;
		logic [63:0] prod;
		logic [63:0] res;
		int unsigned odd;
		pos = '0;
		neg = '0;
		if (i == 0) begin
			res = 64'd45 << CORDIC_ZQ;
		end else begin
			for (int unsigned k = 0; k < 32; k++) begin
				odd = 2 * k + 1;
				if (i * odd <= 62) begin
					term = udiv64(64'd1 << (62 - i * odd), 64'(odd));
					if (k[0])
						neg = neg + term;
					else
						pos = pos + term;
				end
			end
			rad32 = ((pos - neg) + (64'd1 << 29)) >> 30;
			prod  = rad32 * DEG_PER_RAD_Q26;
			res   = (prod + (64'd1 << 27)) >> 28;
		end
		return res;
	endfunction

endpackage

@@ rtl/ictf_cordic.sv @@
// Iterative vectoring CORDIC: atan2(y, x) in degrees, one rotation per cycle.
module ictf_cordic
	import ictf_pkg::*;
#(
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] y_in,
	input  logic signed [15:0] x_in,
	output logic               done,
	output logic signed [31:0] angle
);

	localparam int CW = 48;
	localparam int ZW = 42;
	localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int RS = CORDIC_ZQ - ANGLE_FRAC_BITS;

	logic signed [ZW-1:0] tab [CORDIC_STEPS];
	logic signed [CW-1:0] x_q, y_q, dx, dy, x0, y0;
	logic signed [ZW-1:0] z_q, z0, zr, zs;
	logic [SW-1:0] step_q;
	logic busy_q, done_q, zero_q;

	// angle table, built at elaboration
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_tab
		assign tab[g] = ZW'(atan_deg_q30(g));
	end

	// pre-rotation by 180 degrees for the left half plane
	always_comb begin
		x0 = CW'(x_in) <<< CORDIC_ZQ;
		y0 = CW'(y_in) <<< CORDIC_ZQ;
		z0 = '0;
		if (x_in < 0) begin
			x0 = -x0;
			y0 = -y0;
			z0 = (y_in >= 0) ? (ZW'(180) <<< CORDIC_ZQ) : -(ZW'(180) <<< CORDIC_ZQ);
		end
	end

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;

	// rotation sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// vector and angle registers
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			zero_q <= (x_in == 0) && (y_in == 0);
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + tab[step_q];
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - tab[step_q];
			end
		end
	end

	// round half away from zero to the output format
	assign zr = z_q + (ZW'(1) <<< (RS - 1)) - $signed({{(ZW-1){1'b0}}, z_q[ZW-1]});
	assign zs = zr >>> RS;
	assign angle = zero_q ? '0 : 32'(zs);
	assign done = done_q;

endmodule

@@ rtl/ictf_div.sv @@
// Reciprocal divider: quotient estimate, back-multiply, then compare-and-subtract fix-up.
module ictf_div
	import ictf_pkg::*;
#(
	parameter int QW = 28,
	parameter int NW = 56
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NW-1:0]    num,
	input  logic [DEN_W-1:0] den,
	input  logic [31:0]      rcp,
	output logic             done,
	output logic [QW-1:0]    quo
);

	// estimate uses the top 32 numerator bits
	localparam int SH = RCP_SHIFT - (NW - 32);
	localparam int RW = DEN_W + 2;

	div_state_t st_q, st_d;

	logic [NW-1:0] num_q;
	logic [31:0] nhi_q, ma, mb;
	logic [63:0] prod;
	logic [QW-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic done_q, ge;

	assign ge = rem_q >= RW'(den);

	// next phase
	always_comb begin
		st_d = st_q;
		case (st_q)
			DV_IDLE: if (start) st_d = DV_MUL1;
			DV_MUL1: st_d = DV_MUL2;
			DV_MUL2: st_d = DV_FIX;
			DV_FIX:  if (!ge) st_d = DV_IDLE;
			default: st_d = DV_IDLE;
		endcase
	end

	// multiplier operands: numerator * reciprocal, then estimate * divisor
	always_comb begin
		if (st_q == DV_MUL1) begin
			ma = nhi_q;
			mb = rcp;
		end else begin
			ma = 32'(quo_q);
			mb = 32'(den);
		end
	end

	assign prod = 64'(ma) * 64'(mb);

	// phase register and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DV_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == DV_FIX) && !ge;
		end
	end

	// estimate never exceeds the true quotient; remainder is fixed up from below
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			nhi_q <= num[NW-1:NW-32];
		end
		case (st_q)
			DV_MUL1: quo_q <= QW'(prod >> SH);
			DV_MUL2: rem_q <= RW'(num_q - NW'(prod));
			DV_FIX: begin
				if (ge) begin
					rem_q <= rem_q - RW'(den);
					quo_q <= quo_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

@@ rtl/imu_complementary_tilt_filter.sv @@
// Roll/pitch complementary filter: sequencer, shared multiplier and blend.
// The seed word runs only the two CORDIC angles; later words add, per axis, the gyro
// multiply, a reciprocal divide with its fix-ups and the blend.
// A new word is taken only in the idle state; one CORDIC, one reciprocal divider
// and one multiplier are reused for both axes. The output register frees the input side.
// Reset: alpha 64881, full scale 250 dps, angles zero, next word seeds the angles.
module imu_complementary_tilt_filter
	import ictf_pkg::*;
#(
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [15:0]   accel_x,
	input  logic signed [15:0]   accel_y,
	input  logic signed [15:0]   accel_z,
	input  logic signed [15:0]   gyro_x,
	input  logic signed [15:0]   gyro_y,
	input  logic [19:0]          dt_us,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   roll,
	output logic signed [31:0]   pitch
);

	localparam int QW = ANGLE_FRAC_BITS + 12;
	localparam int NW = ANGLE_FRAC_BITS + 40;
	localparam int MW = 54;
	localparam int VW = 56;

	ictf_state_t state_q, state_d;

	logic [CFG_W-1:0] alpha_q, alpha_c;
	logic [1:0] gfs_q;
	logic axis_q, seeded_q, out_valid_q, emit_ok, accept;
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
	logic [19:0] dt_q;
	logic signed [31:0] acc_q [2];
	logic signed [31:0] ang_q [2];
	logic signed [31:0] roll_q, pitch_q;
	logic signed [QW:0] inc_q;
	logic signed [MW-1:0] prod_q, prod;
	logic signed [17:0] ma;
	logic signed [35:0] mb, d;
	logic cor_start, cor_done, div_start, div_done;
	logic signed [15:0] cor_y;
	logic signed [31:0] cor_angle;
	logic signed [36:0] p;
	logic gneg;
	logic [34:0] mag;
	logic [NW-1:0] m10, num;
	logic [DEN_W-1:0] den;
	logic [31:0] rcp;
	logic [QW-1:0] quo;
	logic signed [VW-1:0] v, vr, vs;
	logic signed [31:0] blend_sat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			gfs_q   <= FS_250;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA:   alpha_q <= cfg_data;
				REG_GYRO_FS: gfs_q   <= cfg_data[1:0];
				default:     ;
			endcase
		end
	end

	assign alpha_c = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_ATAN_GO;
			ST_ATAN_GO:  state_d = ST_ATAN_RUN;
			ST_ATAN_RUN: begin
				if (cor_done) begin
					if (!axis_q)
						state_d = ST_ATAN_GO;
					else
						state_d = seeded_q ? ST_GMUL : ST_EMIT;
				end
			end
			ST_GMUL:     state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_RUN;
			ST_DIV_RUN:  if (div_done) state_d = ST_BMUL;
			ST_BMUL:     state_d = ST_BFIN;
			ST_BFIN:     state_d = axis_q ? ST_EMIT : ST_GMUL;
			ST_EMIT:     if (emit_ok) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		cor_start = (state_q == ST_ATAN_GO);
		div_start = (state_q == ST_DIV_GO);
	end

	assign accept  = in_valid && !in_stall;
	assign emit_ok = !out_valid_q || !out_stall;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
			ang_q[0]    <= '0;
			ang_q[1]    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && emit_ok)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) axis_q <= 1'b0;
				ST_ATAN_RUN: begin
					if (cor_done) begin
						axis_q <= ~axis_q;
						if (!seeded_q)
							ang_q[axis_q] <= cor_angle;
					end
				end
				ST_BFIN: begin
					ang_q[axis_q] <= blend_sat;
					axis_q        <= ~axis_q;
				end
				ST_EMIT: begin
					if (emit_ok)
						seeded_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// word capture and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
			gx_q <= gyro_x;
			gy_q <= gyro_y;
			dt_q <= dt_us;
		end
		if (state_q == ST_ATAN_RUN && cor_done)
			acc_q[axis_q] <= cor_angle;
		if (state_q == ST_GMUL || state_q == ST_BMUL)
			prod_q <= prod;
		if (state_q == ST_DIV_RUN && div_done)
			inc_q <= gneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		if (state_q == ST_EMIT && emit_ok) begin
			roll_q  <= ang_q[0];
			pitch_q <= ang_q[1];
		end
	end

	// shared multiplier: gyro * dt, then alpha * (angle + increment - accel angle)
	assign d = 36'(ang_q[axis_q]) + 36'(inc_q) - 36'(acc_q[axis_q]);
	always_comb begin
		if (state_q == ST_BMUL) begin
			ma = $signed({1'b0, alpha_c});
			mb = d;
		end else begin
			ma = 18'(axis_q ? gy_q : gx_q);
			mb = $signed({16'd0, dt_q});
		end
	end
	assign prod = ma * mb;

	// divider operand: |gyro*dt| * 10 * 2^F + den/2
	assign p    = prod_q[36:0];
	assign gneg = p[36];
	assign mag  = 35'(gneg ? -p : p);
	assign m10  = (NW'(mag) << 3) + (NW'(mag) << 1);
	assign den  = gyro_den(gfs_q);
	assign rcp  = gyro_recip(gfs_q);
	assign num  = (m10 << ANGLE_FRAC_BITS) + NW'(den >> 1);

	// blend: round half away from zero, then saturate
	assign v  = VW'(prod_q) + (VW'(acc_q[axis_q]) <<< 16);
	assign vr = v + VW'(32768) - $signed({{(VW-1){1'b0}}, v[VW-1]});
	assign vs = vr >>> 16;
	always_comb begin
		if (vs > VW'(64'sd2147483647))
			blend_sat = 32'sh7fffffff;
		else if (vs < -VW'(64'sd2147483648))
			blend_sat = 32'sh80000000;
		else
			blend_sat = 32'(vs);
	end

	assign cor_y = axis_q ? ax_q : ay_q;

	ictf_cordic #(
		.CORDIC_STEPS    (CORDIC_STEPS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.y_in   (cor_y),
		.x_in   (az_q),
		.done   (cor_done),
		.angle  (cor_angle)
	);

	ictf_div #(
		.QW (QW),
		.NW (NW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.rcp    (rcp),
		.done   (div_done),
		.quo    (quo)
	);

	assign out_valid = out_valid_q;
	assign roll      = roll_q;
	assign pitch     = pitch_q;

endmodule
